// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/htsed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_pkg
// Types, character codes and the entity table for the tag stripper and
// entity decoder.
// ----------------------------------------------------------------------------
package htsed_pkg;

  // Input transaction: one raw text byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } item_t;

  // Result transaction: one cleaned byte or an empty end marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_result;
  } result_t;

  // Collapser operation passed from front to back
  typedef struct packed {
    logic [7:0] ch;   // byte fed to the collapser
    logic       grp;  // belongs to the final input transaction of the text
    logic       fin;  // end-of-text marker, ch unused
  } op_t;

  // Front sequencer states
  typedef enum logic [2:0] {
    F_IDLE,
    F_REL_PRE,
    F_FRESH,
    F_REL_END,
    F_END
  } front_state_e;

  // Character codes
  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam int unsigned NumEnt    = 6;
  localparam int unsigned PfxDepth  = 5;
  localparam int unsigned EntMaxLen = 6;

  // Entity spellings, padded with zero
  localparam logic [7:0] EntText [NumEnt][EntMaxLen] = '{
    '{CharAmp, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // lt
    '{CharAmp, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // gt
    '{CharAmp, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // amp
    '{CharAmp, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},  // nbsp
    '{CharAmp, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},  // apos
    '{CharAmp, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}   // quot
  };
  localparam logic [3:0] EntLen [NumEnt] = '{4'd4, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6};
  localparam logic [7:0] EntRepl [NumEnt] = '{
    CharLt, CharGt, CharAmp, CharSpace, 8'h27, 8'h22
  };

  typedef struct packed {
    logic       found;     // prefix plus byte still spells an entity
    logic       complete;  // and it is a whole entity
    logic [7:0] repl;
  } match_t;

  // Match the pending prefix extended by one byte against the entity table
  function automatic match_t ent_match(input logic [PfxDepth-1:0][7:0] pfx,
                                       input logic [2:0] plen,
                                       input logic [7:0] ch);
    match_t     r;
    logic       ok;
    logic [3:0] need;
    r    = '0;
    need = {1'b0, plen} + 4'd1;
    for (int e = 0; e < NumEnt; e++) begin
      ok = (EntLen[e] >= need);
      for (int k = 0; k < PfxDepth; k++) begin
        if ((3'(k) < plen) && (pfx[k] != EntText[e][k])) ok = 1'b0;
      end
      if (ok && (EntText[e][plen] == ch) && !r.found) begin
        r.found    = 1'b1;
        r.complete = (EntLen[e] == need);
        r.repl     = EntRepl[e];
      end
    end
    return r;
  endfunction

  // Whitespace as the collapser sees it
  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CharSpace) || (ch == CharTab) || (ch == CharLf) || (ch == CharCr);
  endfunction

endpackage

// ===== rtl/html_tag_strip_entity_decode_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted plain byte goes through the operation queue and the output FIFO.
// Rate: one byte per cycle while the front is idle and the operation queue has room;
// broken prefixes go out bytewise, a text end adds an end op, a space stalls the back.
// Front and back meet at an operation queue; results leave through an output FIFO.
// Reset: asynchronous, active low; clears all control state, ready at once.
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode_core
// Strips HTML tags, decodes six named entities and collapses whitespace.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode_core #(
  parameter int unsigned OpqDepth = 4,
  parameter int unsigned OutDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  htsed_pkg::item_t     in_item_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output htsed_pkg::result_t   out_result_o
);

  import htsed_pkg::*;

  logic    op_push, op_full, op_empty, op_pop;
  op_t     op_wr, op_rd;
  logic    res_push, res_full;
  result_t res_wr;

  // Front: classify input transactions
  htsed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .op_push_o (op_push),
    .op_o      (op_wr),
    .op_full_i (op_full)
  );

  // Decouple front and back
  htsed_fifo #(
    .Depth (OpqDepth),
    .Width ($bits(op_t))
  ) u_opq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (op_push),
    .wr_data_i (op_wr),
    .full_o    (op_full),
    .rd_en_i   (op_pop),
    .rd_data_o (op_rd),
    .empty_o   (op_empty)
  );

  // Back: collapse whitespace and frame the text
  htsed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!op_empty),
    .op_i       (op_rd),
    .op_pop_o   (op_pop),
    .res_push_o (res_push),
    .res_o      (res_wr),
    .res_full_i (res_full)
  );

  // Output queue towards the consumer
  htsed_fifo #(
    .Depth (OutDepth),
    .Width ($bits(result_t))
  ) u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_wr),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (out_result_o),
    .empty_o   (empty)
  );

endmodule

// ===== rtl/htsed_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_fifo
// Small register FIFO with count-based full and empty flags.
// ----------------------------------------------------------------------------
module htsed_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the written entry
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== rtl/htsed_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_front
// Tag stripping and entity matching. Turns each input transaction into a
// short run of collapser operations, releasing unmatched prefixes bytewise.
// ----------------------------------------------------------------------------
module htsed_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  htsed_pkg::item_t     in_item_i,
  output logic                 full,
  output logic                 op_push_o,
  output htsed_pkg::op_t       op_o,
  input  logic                 op_full_i
);

  import htsed_pkg::*;

  front_state_e              state_q, state_d;
  logic                      tag_q, tag_d;
  logic [2:0]                plen_q, plen_d;
  logic [2:0]                k_q, k_d;
  logic [PfxDepth-1:0][7:0]  pfx_q, pfx_d;
  logic [7:0]                c_q, c_d;
  logic                      last_q, last_d;

  logic                      accept;
  logic                      can_go;
  match_t                    mt;

  // Fresh byte handling, shared by the accept path and the FRESH state
  logic [7:0]                fr_ch;
  logic                      fr_last;
  logic                      fr_op_v;
  logic [7:0]                fr_op_ch;
  logic                      fr_tag;
  logic [2:0]                fr_plen;
  front_state_e              fr_next;

  assign can_go = !op_full_i;
  assign full   = (state_q != F_IDLE) || op_full_i;
  assign accept = push && !full;
  assign mt     = ent_match(pfx_q, plen_q, in_item_i.in_byte);

  // Classify a byte outside the prefix path
  always_comb begin
    fr_ch    = (state_q == F_IDLE) ? in_item_i.in_byte : c_q;
    fr_last  = (state_q == F_IDLE) ? in_item_i.end_of_text : last_q;
    fr_op_v  = 1'b0;
    fr_op_ch = fr_ch;
    fr_tag   = tag_q;
    fr_plen  = '0;
    priority if (fr_ch == CharLt) begin
      fr_tag = 1'b1;
    end else if (fr_ch == CharGt) begin
      fr_tag   = 1'b0;
      fr_op_v  = 1'b1;
      fr_op_ch = CharSpace;
    end else if (tag_q) begin
      fr_op_v = 1'b0;
    end else if (fr_ch == CharAmp) begin
      fr_plen = 3'd1;
    end else begin
      fr_op_v = 1'b1;
    end
    if (fr_last) fr_next = (fr_plen != '0) ? F_REL_END : F_END;
    else fr_next = F_IDLE;
  end

  // Sequence the operations of one transaction
  always_comb begin
    state_d   = state_q;
    tag_d     = tag_q;
    plen_d    = plen_q;
    k_d       = k_q;
    pfx_d     = pfx_q;
    c_d       = c_q;
    last_d    = last_q;
    op_push_o = 1'b0;
    op_o      = '0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          c_d    = in_item_i.in_byte;
          last_d = in_item_i.end_of_text;
          op_o.grp = in_item_i.end_of_text;
          if (plen_q != '0) begin
            if (mt.found && mt.complete) begin
              op_push_o = 1'b1;
              op_o.ch   = mt.repl;
              plen_d    = '0;
              state_d   = in_item_i.end_of_text ? F_END : F_IDLE;
            end else if (mt.found) begin
              pfx_d[plen_q] = in_item_i.in_byte;
              plen_d        = plen_q + 3'd1;
              k_d           = '0;
              state_d       = in_item_i.end_of_text ? F_REL_END : F_IDLE;
            end else begin
              // Release the broken prefix, then handle the byte afresh
              op_push_o = 1'b1;
              op_o.ch   = pfx_q[0];
              k_d       = 3'd1;
              state_d   = (plen_q == 3'd1) ? F_FRESH : F_REL_PRE;
            end
          end else begin
            op_push_o = fr_op_v;
            op_o.ch   = fr_op_ch;
            tag_d     = fr_tag;
            plen_d    = fr_plen;
            if (fr_plen != '0) pfx_d[0] = CharAmp;
            k_d       = '0;
            state_d   = fr_next;
          end
        end
      end
      F_REL_PRE: begin
        if (can_go) begin
          op_push_o = 1'b1;
          op_o.ch   = pfx_q[k_q];
          op_o.grp  = last_q;
          k_d       = k_q + 3'd1;
          if (k_d == plen_q) state_d = F_FRESH;
        end
      end
      F_FRESH: begin
        if (can_go) begin
          op_push_o = fr_op_v;
          op_o.ch   = fr_op_ch;
          op_o.grp  = last_q;
          tag_d     = fr_tag;
          plen_d    = fr_plen;
          if (fr_plen != '0) pfx_d[0] = CharAmp;
          k_d       = '0;
          state_d   = fr_next;
        end
      end
      F_REL_END: begin
        if (can_go) begin
          op_push_o = 1'b1;
          op_o.ch   = pfx_q[k_q];
          op_o.grp  = 1'b1;
          k_d       = k_q + 3'd1;
          if (k_d == plen_q) begin
            plen_d  = '0;
            state_d = F_END;
          end
        end
      end
      F_END: begin
        if (can_go) begin
          op_push_o = 1'b1;
          op_o.grp  = 1'b1;
          op_o.fin  = 1'b1;
          tag_d     = 1'b0;
          plen_d    = '0;
          state_d   = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      tag_q   <= 1'b0;
      plen_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      plen_q  <= plen_d;
      k_q     <= k_d;
    end
  end

  // Hold prefix bytes and the deferred transaction
  always_ff @(posedge clk_i) begin
    pfx_q  <= pfx_d;
    c_q    <= c_d;
    last_q <= last_d;
  end

endmodule

// ===== rtl/htsed_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_back
// Whitespace collapser. Folds whitespace runs to one space, drops leading
// and trailing space and marks the final result of each text.
// ----------------------------------------------------------------------------
module htsed_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  input  htsed_pkg::op_t       op_i,
  output logic                 op_pop_o,
  output logic                 res_push_o,
  output htsed_pkg::result_t   res_o,
  input  logic                 res_full_i
);

  import htsed_pkg::*;

  logic    after_ws_q, after_ws_d;
  logic    pend_q, pend_d;
  logic    hold_v_q, hold_v_d;
  result_t hold_q, hold_d;
  result_t new_res;

  // Collapse one operation, at most one result a cycle
  always_comb begin
    after_ws_d = after_ws_q;
    pend_d     = pend_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    new_res    = '0;
    new_res.byte_valid = 1'b1;
    new_res.out_byte   = pend_q ? CharSpace : op_i.ch;
    if (op_valid_i) begin
      priority if (op_i.fin) begin
        // Close the text: flag the held result or send an empty marker
        res_push_o = 1'b1;
        if (hold_v_q) begin
          res_o             = hold_q;
          res_o.last_result = 1'b1;
        end else begin
          res_o.last_result = 1'b1;
        end
        if (!res_full_i) begin
          op_pop_o   = 1'b1;
          hold_v_d   = 1'b0;
          after_ws_d = 1'b1;
          pend_d     = 1'b0;
        end
      end else if (is_ws(op_i.ch)) begin
        op_pop_o = 1'b1;
        if (!after_ws_q) pend_d = 1'b1;
        after_ws_d = 1'b1;
      end else begin
        if (op_i.grp) begin
          res_push_o = hold_v_q;
          res_o      = hold_q;
        end else begin
          res_push_o = 1'b1;
          res_o      = new_res;
        end
        if (!(res_push_o && res_full_i)) begin
          if (op_i.grp) begin
            hold_d   = new_res;
            hold_v_d = 1'b1;
          end
          if (pend_q) begin
            pend_d = 1'b0;
          end else begin
            after_ws_d = 1'b0;
            op_pop_o   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_ws_q <= 1'b1;
      pend_q     <= 1'b0;
      hold_v_q   <= 1'b0;
    end else begin
      after_ws_q <= after_ws_d;
      pend_q     <= pend_d;
      hold_v_q   <= hold_v_d;
    end
  end

  // Keep the latest result of the final transaction
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

// ===== rtl/htsed_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsed_checker
// Port-level checks on the result stream of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htsed_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input htsed_pkg::item_t     in_item_i,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input htsed_pkg::result_t   out_result_o
);

  import htsed_pkg::*;

  logic    space_or_start_q;
  logic    pop_xfer;
  logic    push_xfer;
  item_t   unused_item;

  assign pop_xfer    = pop && !empty;
  assign push_xfer   = push && !full;
  assign unused_item = in_item_i;

  // Track whether the previous delivered result was a space or a text start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_or_start_q <= 1'b1;
    end else if (pop_xfer) begin
      if (out_result_o.last_result) space_or_start_q <= 1'b1;
      else if (out_result_o.byte_valid)
        space_or_start_q <= (out_result_o.out_byte == CharSpace);
    end
  end

  `ASSERT_STD(a_hold_stalled, !empty && !pop |=> $stable(out_result_o) && !empty, "result changed while stalled")
  `ASSERT_STD(a_marker_form, !empty && !out_result_o.byte_valid |-> out_result_o.last_result && (out_result_o.out_byte == 8'h00), "malformed end marker")
  `ASSERT_STD(a_no_raw_ws, !empty && out_result_o.byte_valid |-> (out_result_o.out_byte != CharTab) && (out_result_o.out_byte != CharLf) && (out_result_o.out_byte != CharCr), "uncollapsed whitespace")
  `ASSERT_STD(a_no_double_space, !empty && out_result_o.byte_valid && space_or_start_q |-> out_result_o.out_byte != CharSpace, "leading or repeated space")
  `ASSERT_STD(a_no_trailing_space, !empty && out_result_o.byte_valid && out_result_o.last_result |-> out_result_o.out_byte != CharSpace || (push_xfer && unused_item.end_of_text && !push_xfer), "trailing space at end of text")

endmodule

bind html_tag_strip_entity_decode_core htsed_checker u_checker (.*);
